FILE: design/mrpt_pkg.sv
// Shared types and constants of the Miller-Rabin prime test block.
package mrpt_pkg;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_RED   = 7'b0000010,
    ST_SPLIT = 7'b0000100,
    ST_POW   = 7'b0001000,
    ST_SQR   = 7'b0010000,
    ST_WAIT  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } mrpt_state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } mrpt_mm_ctl_t;

endpackage

FILE: design/mrpt_modmul.sv
// Bit-serial modular multiplier: computes x * y mod m one bit of y per cycle.
module mrpt_modmul #(
  parameter int NUM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] x,
  input  logic [NUM_WIDTH-1:0] y,
  input  logic [NUM_WIDTH-1:0] m,
  output mrpt_pkg::mrpt_mm_ctl_t ctl,
  output logic [NUM_WIDTH-1:0] prod
);
  import mrpt_pkg::*;

  localparam int CW = $clog2(NUM_WIDTH + 1);

  logic [NUM_WIDTH-1:0] acc_r, acc_nxt, x_r, m_r, y_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r, done_r;
  logic [NUM_WIDTH:0]   dbl, dbl_red, add_s;

  // Horner step, MSB of y first: acc = 2*acc (+ x), each reduced once.
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    add_s   = dbl_red + {1'b0, x_r};
    if (y_r[NUM_WIDTH-1]) begin
      acc_nxt = (add_s >= {1'b0, m_r}) ? NUM_WIDTH'(add_s - {1'b0, m_r})
                                       : NUM_WIDTH'(add_s);
    end else begin
      acc_nxt = NUM_WIDTH'(dbl_red);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      x_r   <= x;
      y_r   <= y;
      m_r   <= m;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      y_r   <= {y_r[NUM_WIDTH-2:0], 1'b0};
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;
  assign prod      = acc_r;
endmodule

FILE: design/miller_rabin_prime_test.sv
// Top level of the Miller-Rabin prime test block.
// Each input beat is one round: candidate p, base a, and last_round. The
// block accepts a beat only while idle (in_stall high otherwise). It reduces
// a mod p by bit-serial restoring subtraction, shifts p-1 right to find d
// and b (one bit per cycle), then runs a^d mod p by square-and-multiply
// and up to b further squarings. Every modular product goes through one
// shared bit-serial multiplier. Since d has at most NUM_WIDTH-1 bits and
// each bit costs a squaring and possibly a multiply, a round needs at most
// about 2*NUM_WIDTH products.
// The witness flag is sticky over rounds. A beat with last_round set
// yields one output beat carrying probably_prime, held in an output
// register until the receiver drops out_stall; the flag then clears and
// the next round is taken. Beats without last_round yield no output.
// Candidate one passes and even candidates, zero included, fail at once.
// Reset (rst_n low, synchronous) clears the flag and returns to idle.
module miller_rabin_prime_test #(
  parameter int NUM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_candidate,
  input  logic [31:0] in_base,
  input  logic        in_last_round,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_probably_prime
);
  import mrpt_pkg::*;

  localparam int CW = $clog2(NUM_WIDTH + 1);
  localparam logic [NUM_WIDTH-1:0] One = NUM_WIDTH'(1);

  mrpt_state_t          state_r;
  logic [NUM_WIDTH-1:0] p_r, x_r, acc_r, e_r, pm1;
  logic [NUM_WIDTH-1:0] a_sh_r;   // base bits fed into the reducer
  logic [NUM_WIDTH-1:0] rem_r;
  logic [CW-1:0]        cnt_r, b_r;
  logic                 last_r, wit_r, sq_phase_r, out_valid_r, out_pp_r;
  logic                 mm_start;
  logic [NUM_WIDTH-1:0] mm_x, mm_y, mm_prod;
  mrpt_mm_ctl_t         mm_ctl;
  logic [NUM_WIDTH:0]   rem_sh;
  logic                 wit_now;

  assign pm1 = p_r - One;

  mrpt_modmul #(.NUM_WIDTH(NUM_WIDTH)) u_mm (
    .clk(clk), .rst_n(rst_n), .start(mm_start), .x(mm_x), .y(mm_y),
    .m(p_r), .ctl(mm_ctl), .prod(mm_prod)
  );

  assign rem_sh   = {rem_r, a_sh_r[NUM_WIDTH-1]};
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_probably_prime = out_pp_r;

  // Multiplier operands: in ST_POW, sq_phase_r low multiplies acc by x and
  // high squares x; in ST_SQR, x is always squared.
  always_comb begin
    mm_x = x_r;
    mm_y = x_r;
    if (state_r == ST_POW && !sq_phase_r) mm_x = acc_r;
  end

  always_comb begin
    mm_start = 1'b0;
    if (state_r == ST_POW && !mm_ctl.busy && !mm_ctl.done && e_r != '0 &&
        (sq_phase_r || e_r[0])) mm_start = 1'b1;
    if (state_r == ST_SQR && !mm_ctl.busy && !mm_ctl.done && b_r != '0 &&
        x_r != pm1 && !(cnt_r == '0 && x_r == One)) mm_start = 1'b1;
  end

  assign wit_now = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            p_r    <= in_candidate[NUM_WIDTH-1:0];
            a_sh_r <= in_base[NUM_WIDTH-1:0];
            last_r <= in_last_round;
            rem_r  <= '0;
            cnt_r  <= CW'(NUM_WIDTH);
            if (in_candidate[NUM_WIDTH-1:0] == One) begin
              state_r <= ST_WAIT;
            end else if (!in_candidate[0]) begin
              wit_r   <= wit_now;
              state_r <= ST_WAIT;
            end else begin
              state_r <= ST_RED;
            end
          end
        end
        ST_RED: begin
          // Restoring remainder, one base bit per cycle.
          rem_r  <= (rem_sh >= {1'b0, p_r}) ? NUM_WIDTH'(rem_sh - {1'b0, p_r})
                                            : NUM_WIDTH'(rem_sh);
          a_sh_r <= {a_sh_r[NUM_WIDTH-2:0], 1'b0};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            state_r <= ST_SPLIT;
            e_r     <= pm1;
            b_r     <= '0;
          end
        end
        ST_SPLIT: begin
          x_r <= rem_r;
          if (!e_r[0]) begin
            e_r <= e_r >> 1;
            b_r <= b_r + 1'b1;
          end else begin
            acc_r      <= One;
            sq_phase_r <= 1'b0;
            state_r    <= ST_POW;
          end
        end
        ST_POW: begin
          if (e_r == '0) begin
            x_r     <= acc_r;
            cnt_r   <= '0;
            state_r <= ST_SQR;
          end else if (mm_ctl.done) begin
            if (sq_phase_r) begin
              x_r <= mm_prod;
              e_r <= e_r >> 1;
            end else begin
              acc_r <= mm_prod;
            end
            sq_phase_r <= !sq_phase_r;
          end else if (!mm_ctl.busy && !sq_phase_r && !e_r[0]) begin
            sq_phase_r <= 1'b1;
          end
        end
        ST_SQR: begin
          // cnt_r marks that at least one squaring has been done. Once all
          // b squarings are used up the value is no longer compared.
          if (cnt_r == '0 && x_r == One) begin
            state_r <= ST_WAIT;
          end else if (b_r == '0) begin
            wit_r   <= 1'b1;
            state_r <= ST_WAIT;
          end else if (x_r == pm1) begin
            state_r <= ST_WAIT;
          end else if (mm_ctl.done) begin
            x_r   <= mm_prod;
            b_r   <= b_r - 1'b1;
            cnt_r <= CW'(1);
          end
        end
        ST_WAIT: begin
          if (last_r) begin
            out_valid_r <= 1'b1;
            out_pp_r    <= !wit_r;
            state_r     <= ST_OUT;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            wit_r       <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

FILE: design/mrpt_checker.sv
// Port-level checker for the Miller-Rabin prime test block, with its bind.
module mrpt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_probably_prime
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_probably_prime))
    else $error("result dropped or changed while stalled");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result waits");
  a_one_round: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken without work");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");
endmodule

bind miller_rabin_prime_test mrpt_checker u_mrpt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_probably_prime(out_probably_prime)
);

FILE: sim/mrpt_verdict_checker.sv
// Verdict predictor and output comparison for the Miller-Rabin prime test block.
`timescale 1ns / 100ps
module mrpt_verdict_checker #(
  parameter int NUM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_candidate,
  input  logic [31:0] in_base,
  input  logic        in_last_round,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_probably_prime,
  output int          fail_count,
  output int          pending,
  output int          verdict_count
);

  bit verdict_q[$];
  bit seen_witness;

  function automatic longint unsigned width_mask();
    return (64'd1 << NUM_WIDTH) - 64'd1;
  endfunction

  function automatic longint unsigned mod_power(longint unsigned a, longint unsigned e,
                                                longint unsigned n);
    longint unsigned r;
    r = 64'd1 % n;
    while (e != 0) begin
      if (e[0]) r = (r * a) % n;
      a = (a * a) % n;
      e = e >> 1;
    end
    return r;
  endfunction

  // True when base a shows candidate p to be composite in this round.
  function automatic bit round_witness(longint unsigned p, longint unsigned a);
    longint unsigned d;
    longint unsigned x;
    int              twos;
    if (p == 1) return 1'b0;
    if (p[0] == 1'b0) return 1'b1;
    d    = p - 1;
    twos = 0;
    while (d[0] == 1'b0) begin
      d = d >> 1;
      twos++;
    end
    x = mod_power(a % p, d, p);
    if (x == 1) return 1'b0;
    for (int i = 0; i < twos; i++) begin
      if (x == p - 1) return 1'b0;
      x = (x * x) % p;
    end
    return 1'b1;
  endfunction

  assign pending = verdict_q.size();

  always @(posedge clk) begin
    bit wit;
    bit want;
    if (!rst_n) begin
      seen_witness  = 1'b0;
      fail_count    = 0;
      verdict_count = 0;
      verdict_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        wit = round_witness(in_candidate & width_mask(), in_base & width_mask());
        seen_witness = seen_witness | wit;
        if (in_last_round) begin
          verdict_q.push_back(!seen_witness);
          seen_witness = 1'b0;
        end
      end
      if (out_valid && !out_stall) begin
        verdict_count++;
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict beat, expected none, actual %0b",
                   $time, out_probably_prime);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_probably_prime !== want) begin
            $display("%0t: probably_prime mismatch, expected %0b, actual %0b",
                     $time, want, out_probably_prime);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

FILE: sim/tb.sv
// Testbench top for the Miller-Rabin prime test block: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module tb;

  localparam int NUM_WIDTH = 32;
  // A quiet stretch far past the longest possible round means the block has hung.
  localparam int HANG_LIMIT = 40000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_candidate = '0;
  logic [31:0] in_base = '0;
  logic        in_last_round = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_probably_prime;

  int fail_count;
  int pending;
  int verdict_count;
  int rounds_sent = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  // While calm is set neither side inserts idle cycles.
  bit calm = 1'b0;

  always #5 clk = ~clk;

  miller_rabin_prime_test #(.NUM_WIDTH(NUM_WIDTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_candidate(in_candidate), .in_base(in_base), .in_last_round(in_last_round),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_probably_prime(out_probably_prime)
  );

  mrpt_verdict_checker #(.NUM_WIDTH(NUM_WIDTH)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_candidate(in_candidate), .in_base(in_base), .in_last_round(in_last_round),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_probably_prime(out_probably_prime),
    .fail_count(fail_count), .pending(pending), .verdict_count(verdict_count)
  );

  // Unless calm is set, the receiver may hold off after each accepted verdict.
  // Only one nonblocking write to out_stall happens per edge.
  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      n = calm ? 0 : $urandom_range(4);
      stall_left = n;
      out_stall <= (n != 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: counts edges on which neither channel moved a beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else if (rst_n) begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("tb: watchdog expired with %0d verdicts outstanding", pending);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Sends one round. It is entered on an edge where the previous beat was
  // accepted (or after reset), so in_valid is only lowered when a gap
  // follows; a zero gap keeps valid high and just swaps the payload.
  task automatic send_round(input logic [31:0] p, input logic [31:0] a, input bit last);
    int gap;
    gap = calm ? 0 : $urandom_range(4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_candidate  <= p;
    in_base       <= a;
    in_last_round <= last;
    do @(posedge clk); while (in_stall);
    rounds_sent++;
  endtask

  // Full test of one candidate: one or more rounds with random bases in the
  // range 2..p-2 when p allows it, verdict on the final round.
  task automatic test_candidate(input logic [31:0] p, input int rounds);
    logic [31:0] a;
    for (int r = 0; r < rounds; r++) begin
      if (p > 32'd3) a = 32'd2 + ($urandom % (p - 32'd3));
      else a = $urandom;
      send_round(p, a, r == rounds - 1);
    end
  endtask

  logic [31:0] primes[] = '{32'd3, 32'd5, 32'd7, 32'd13, 32'd97, 32'd65537,
                            32'd2147483647, 32'd4294967291, 32'd4294967279};
  // Carmichael numbers, strong pseudoprimes and other odd composites fool some bases, so they
  // exercise the squaring chain and the sticky flag over several rounds.
  logic [31:0] tricky[] = '{32'd561, 32'd1105, 32'd2047, 32'd1373653, 32'd25326001,
                            32'd3215031751, 32'd4294967295, 32'd9};

  initial begin
    logic [31:0] p;
    int          pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one passes, zero, two and other even candidates fail.
    send_round(32'd1, 32'd0, 1'b1);
    send_round(32'd0, 32'd5, 1'b1);
    send_round(32'd2, 32'd1, 1'b1);
    send_round(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1);
    // Base zero and base equal to a multiple of the candidate are witnesses.
    send_round(32'd13, 32'd0, 1'b1);
    send_round(32'd13, 32'd26, 1'b1);
    // Base one and base p-1 show no witness at once.
    send_round(32'd4294967291, 32'd1, 1'b1);
    send_round(32'd4294967291, 32'd4294967290, 1'b1);
    // All-ones fields, base larger than the candidate.
    send_round(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_round(32'd97, 32'hFFFF_FFFF, 1'b1);
    // Strong pseudoprime to base 2 caught by base 3 on the second round.
    send_round(32'd2047, 32'd2, 1'b0);
    send_round(32'd2047, 32'd3, 1'b1);
    // Candidate changes between rounds: a witness on the first sticks.
    send_round(32'd561, 32'd2, 1'b0);
    send_round(32'd65537, 32'd3, 1'b1);
    send_round(32'd65537, 32'd3, 1'b0);
    send_round(32'd2147483647, 32'd7, 1'b1);

    // Random part: mostly well-formed tests of real candidates, the rest
    // arbitrary words, with stretches where neither side idles.
    while (rounds_sent < 136) begin
      calm = ($urandom_range(5) == 0);
      pick = $urandom_range(9);
      if (pick < 3) test_candidate(primes[$urandom_range(primes.size() - 1)],
                                   $urandom_range(1, 4));
      else if (pick < 5) test_candidate(tricky[$urandom_range(tricky.size() - 1)],
                                        $urandom_range(1, 4));
      else if (pick < 8) begin
        p = $urandom | 32'd1;
        test_candidate(p, $urandom_range(1, 3));
      end else begin
        send_round($urandom, $urandom, 1'($urandom_range(1)));
      end
    end
    calm = 1'b0;
    send_round(32'd7, 32'd3, 1'b1);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("tb: %0d rounds sent, %0d verdicts checked", rounds_sent, verdict_count);
    $display("tb: covered primes, pseudoprimes, even and degenerate candidates");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
